>>> rtl/stable_min_priority_queue_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted-row priority queue
// Concurrent checks that compile away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef STABLE_MIN_PRIORITY_QUEUE_CORE_MACROS_SVH
`define STABLE_MIN_PRIORITY_QUEUE_CORE_MACROS_SVH

`ifndef SYNTHESIS
// holds in the same cycle
`define SPQ_ASSERT_IMPLIES(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("spq check failed");
// holds in the next cycle
`define SPQ_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("spq check failed");
`else
`define SPQ_ASSERT_IMPLIES(label, clk, rst, cond, prop)
`define SPQ_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif

`endif

>>> rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants of the sorted-row priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int CAPACITY      = 16;
   localparam int PAYLOAD_BITS  = 32;
   localparam int PRIORITY_BITS = 16;
   localparam int COUNT_BITS    = $clog2(CAPACITY + 1);

   localparam logic ACTION_INSERT = 1'b0;
   localparam logic ACTION_REMOVE = 1'b1;

   typedef struct packed {
      logic                            action;
      logic [PAYLOAD_BITS-1:0]         payload;
      logic signed [PRIORITY_BITS-1:0] priority_req;
   } req_type;

   typedef struct packed {
      logic [PAYLOAD_BITS-1:0]         head_payload;
      logic signed [PRIORITY_BITS-1:0] head_priority;
      logic                            is_empty;
      logic                            is_full;
      logic [COUNT_BITS-1:0]           entry_count;
      logic                            insert_rejected;
   } rsp_type;

   // One slot of the sorted row
   typedef struct packed {
      logic                            valid;
      logic signed [PRIORITY_BITS-1:0] pri;
      logic [PAYLOAD_BITS-1:0]         pay;
   } entry_type;

   // Broadcast from the top level to every cell
   typedef struct packed {
      logic      insert_en;
      logic      remove_en;
      entry_type new_entry;
   } cell_ctrl_type;

endpackage

>>> rtl/stable_min_priority_queue_core.sv
// ----------------------------------------------------------------------------
// stable_min_priority_queue_core
// Bounded min priority queue kept as a sorted row of cells, FIFO among ties.
// ----------------------------------------------------------------------------
//  channel | direction | ports                         | moves
//  --------+-----------+-------------------------------+-------------------------
//  req     | in        | req_valid, req_stall, req_data | insert or remove head
//  rsp     | out       | rsp_valid, rsp_stall, rsp_data | head, flags, count
//
//  An accepted request updates every cell at the
//  next edge and its response is valid from then on.
//  A new request is accepted in the same cycle the pending response is taken.
//  The row update is one broadcast compare of the new priority in all cells.
//  Reset empties the row (cell valid bits and count); payload bits are not reset.
//  While a response is held under rsp_stall, req_stall is high and state holds.
// ----------------------------------------------------------------------------
`include "stable_min_priority_queue_core_macros.svh"

module stable_min_priority_queue_core
   import spq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  rejected_ff, rejected_in;

   logic          req_xfer;
   logic          is_full;
   logic          is_empty;
   cell_ctrl_type ctrl;

   entry_type             entry_w [CAPACITY];
   logic [CAPACITY-1:0]   place_w;
   logic [CAPACITY-1:0]   valid_w;

   // Response register parts the two sides; state only moves on a transfer
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_xfer  = req_valid && !req_stall;

   assign is_full  = (count_ff == COUNT_BITS'(CAPACITY));
   assign is_empty = (count_ff == '0);

   always_comb begin
      ctrl.insert_en           = req_xfer && (req_data.action == ACTION_INSERT) && !is_full;
      ctrl.remove_en           = req_xfer && (req_data.action == ACTION_REMOVE) && !is_empty;
      ctrl.new_entry.valid     = 1'b1;
      ctrl.new_entry.pri       = req_data.priority_req;
      ctrl.new_entry.pay       = req_data.payload;
   end

   // Row of cells: each looks at its left neighbor for an insert shift and
   // at its right neighbor for a remove shift.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      entry_type left_e;
      entry_type right_e;
      logic      left_p;

      if (i == 0) begin : g_head
         assign left_e = '0;
         assign left_p = 1'b0;
      end else begin : g_body
         assign left_e = entry_w[i-1];
         assign left_p = place_w[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_e = '0;
      end else begin : g_mid
         assign right_e = entry_w[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .left_entry  (left_e),
         .left_place  (left_p),
         .right_entry (right_e),
         .entry       (entry_w[i]),
         .place       (place_w[i])
      );

      assign valid_w[i] = entry_w[i].valid;
   end

   always_comb begin
      count_in     = count_ff;
      rejected_in  = rejected_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (req_xfer) begin
         rsp_valid_in = 1'b1;
         rejected_in  = (req_data.action == ACTION_INSERT) && is_full;
         priority if (ctrl.insert_en) begin
            count_in = count_ff + 1'b1;
         end else if (ctrl.remove_en) begin
            count_in = count_ff - 1'b1;
         end else begin
            count_in = count_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
      rejected_ff <= rejected_in;
   end

   // Response reads the head cell directly; it holds while stalled
   assign rsp_valid = rsp_valid_ff;
   always_comb begin
      rsp_data.head_payload    = entry_w[0].valid ? entry_w[0].pay : '0;
      rsp_data.head_priority   = entry_w[0].valid ? entry_w[0].pri : '0;
      rsp_data.is_empty        = is_empty;
      rsp_data.is_full         = is_full;
      rsp_data.entry_count     = count_ff;
      rsp_data.insert_rejected = rejected_ff;
   end

   // count tracks the occupied cells
   `SPQ_ASSERT_IMPLIES(a_count_cells, clock, reset, 1'b1,
                       $countones(valid_w) == int'(count_ff))
   // a rejected insert leaves a full row
   `SPQ_ASSERT_IMPLIES(a_reject_full, clock, reset, rsp_valid_ff && rejected_ff, is_full)
   // a remove on an empty row changes nothing
   `SPQ_ASSERT_NEXT(a_remove_empty, clock, reset,
                    req_xfer && (req_data.action == ACTION_REMOVE) && is_empty,
                    is_empty && !rejected_ff)

endmodule

>>> rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row: compares the broadcast entry and shifts.
// ----------------------------------------------------------------------------
`include "stable_min_priority_queue_core_macros.svh"

module spq_cell
   import spq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  entry_type     left_entry,
   input  logic          left_place,
   input  entry_type     right_entry,
   output entry_type     entry,
   output logic          place
);

   entry_type entry_ff;
   entry_type entry_in;

   // new entry goes at or before this slot (strict: equal keys stay ahead)
   assign place = !entry_ff.valid || (entry_ff.pri > ctrl.new_entry.pri);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      priority if (ctrl.insert_en) begin
         priority if (left_place) begin
            entry_in = left_entry;
         end else if (place) begin
            entry_in = ctrl.new_entry;
         end else begin
            entry_in = entry_ff;
         end
      end else if (ctrl.remove_en) begin
         entry_in = right_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
      entry_ff.pri <= entry_in.pri;
      entry_ff.pay <= entry_in.pay;
   end

   // row stays sorted and packed toward the head
   `SPQ_ASSERT_IMPLIES(a_sorted, clock, reset, right_entry.valid,
                       entry_ff.valid && (entry_ff.pri <= right_entry.pri))

endmodule
